FILE: hw/rtl/command_controlled_gated_counter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command controlled gated counter
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMMAND_CONTROLLED_GATED_COUNTER_ASSERT_SVH
`define COMMAND_CONTROLLED_GATED_COUNTER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define CCGC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ccgc: same-cycle check failed");

// next-cycle implication
`define CCGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ccgc: next-cycle check failed");

`else

`define CCGC_ASSERT_IMPLIES(lbl, ante, cons)
`define CCGC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/ccgc_pkg.sv
// ---------------------------------------------------------------------------
// ccgc_pkg
// Shared types and constants of the command controlled gated counter.
// ---------------------------------------------------------------------------
package ccgc_pkg;

    localparam int LINE_MAX = 30;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);

    // item opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_EDGE = 2'd2;

    // three-letter commands, first character in the top byte
    localparam logic [23:0] CMD_AKW = 24'h414B57;
    localparam logic [23:0] CMD_SEL = 24'h53454C;
    localparam logic [23:0] CMD_CNF = 24'h434E46;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [31:0] VAL_CLAMP  = 32'h8000_0000;
    localparam logic [31:0] VAL_SMAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] CNF_LIMIT  = 32'd11;
    localparam logic [31:0] CNF_2R_MIN = 32'd5;
    localparam logic [3:0]  SEL_FLIP   = 4'h8;

    typedef enum logic [2:0] {
        KIND_COUNT      = 3'd0,
        KIND_SELECT     = 3'd1,
        KIND_FLAGS      = 3'd2,
        KIND_BAD_CMD    = 3'd3,
        KIND_OVER_RANGE = 3'd4,
        KIND_TOO_LONG   = 3'd5
    } t_kind;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] pulse_total;
        logic [3:0]  channel_select;
        logic        enable_2r;
        logic        low_rate;
    } t_result;

endpackage

FILE: hw/rtl/ccgc_engine.sv
// ---------------------------------------------------------------------------
// ccgc_engine
// Line parser, command decode and gated edge counter. Computes the result of
// one item from the current state and commits the new state on i_advance.
// ---------------------------------------------------------------------------
module ccgc_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  ccgc_pkg::t_item    i_item,
    output logic               o_has_result,
    output ccgc_pkg::t_result  o_result
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    logic [23:0]                r_prefix,   n_prefix;
    logic [ccgc_pkg::LEN_W-1:0] r_len,      n_len;
    t_phase                     r_phase,    n_phase;
    logic                       r_neg,      n_neg;
    logic [31:0]                r_val,      n_val;
    logic                       r_acq,      n_acq;
    logic [31:0]                r_elapsed,  n_elapsed;
    logic [31:0]                r_window,   n_window;
    logic [31:0]                r_pulse,    n_pulse;
    logic                       r_warned,   n_warned;

    logic [7:0]  w_c;
    logic        w_is_space;
    logic        w_is_digit;
    logic [34:0] w_acc;
    logic [31:0] w_tick_next;
    logic [31:0] w_value;
    logic        w_take_digit;

    assign w_c         = i_item.rx_byte;
    assign w_is_space  = (w_c == ccgc_pkg::CH_SPACE) ||
                         ((w_c >= ccgc_pkg::CH_TAB) && (w_c <= ccgc_pkg::CH_CR));
    assign w_is_digit  = (w_c >= ccgc_pkg::CH_ZERO) && (w_c <= ccgc_pkg::CH_NINE);
    // value * 10 + digit, shifts and adds in one 35-bit sum
    assign w_acc       = ({3'b000, r_val} << 3) + ({3'b000, r_val} << 1) +
                         {27'd0, w_c - ccgc_pkg::CH_ZERO};
    assign w_tick_next = r_elapsed + 32'd1;

    // signed value of the number as a two's complement pattern
    always_comb begin
        if (r_neg) begin
            w_value = 32'd0 - r_val;
        end else if (r_val[31]) begin
            w_value = ccgc_pkg::VAL_SMAX;
        end else begin
            w_value = r_val;
        end
    end

    always_comb begin
        n_prefix     = r_prefix;
        n_len        = r_len;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_val        = r_val;
        n_acq        = r_acq;
        n_elapsed    = r_elapsed;
        n_window     = r_window;
        n_pulse      = r_pulse;
        n_warned     = r_warned;
        w_take_digit = 1'b0;
        o_has_result = 1'b0;
        o_result     = '0;

        unique case (i_item.op)
            ccgc_pkg::OP_TICK: begin
                if (r_acq) begin
                    n_elapsed = w_tick_next;
                    if (w_tick_next >= r_window) begin
                        n_acq                = 1'b0;
                        n_pulse              = 32'd0;
                        o_has_result         = 1'b1;
                        o_result.kind        = ccgc_pkg::KIND_COUNT;
                        o_result.pulse_total = r_pulse;
                    end
                end
            end
            ccgc_pkg::OP_EDGE: begin
                if (r_acq) begin
                    n_pulse = r_pulse + 32'd1;
                end
            end
            ccgc_pkg::OP_BYTE: begin
                if (!r_acq) begin
                    if (w_c == ccgc_pkg::CH_NEWLINE) begin
                        n_prefix     = '0;
                        n_len        = '0;
                        n_phase      = PH_SKIP;
                        n_neg        = 1'b0;
                        n_val        = '0;
                        n_warned     = 1'b0;
                        o_has_result = 1'b1;
                        priority if (r_prefix == ccgc_pkg::CMD_AKW) begin
                            n_window  = w_value;
                            n_elapsed = 32'd0;
                            n_pulse   = 32'd0;
                            if (w_value == 32'd0) begin
                                o_result.kind = ccgc_pkg::KIND_COUNT;
                            end else begin
                                n_acq        = 1'b1;
                                o_has_result = 1'b0;
                            end
                        end else if (r_prefix == ccgc_pkg::CMD_SEL) begin
                            o_result.kind           = ccgc_pkg::KIND_SELECT;
                            o_result.channel_select = w_value[3:0] ^ ccgc_pkg::SEL_FLIP;
                        end else if (r_prefix == ccgc_pkg::CMD_CNF) begin
                            if ($signed(w_value) > $signed(ccgc_pkg::CNF_LIMIT)) begin
                                o_result.kind = ccgc_pkg::KIND_OVER_RANGE;
                            end else begin
                                o_result.kind      = ccgc_pkg::KIND_FLAGS;
                                o_result.enable_2r =
                                    $signed(w_value) > $signed(ccgc_pkg::CNF_2R_MIN);
                                o_result.low_rate  = w_value[0];
                            end
                        end else begin
                            o_result.kind = ccgc_pkg::KIND_BAD_CMD;
                        end
                    end else if (r_len >= ccgc_pkg::LEN_W'(ccgc_pkg::LINE_MAX)) begin
                        // overlong line: warn once, drop the rest
                        if (!r_warned) begin
                            n_warned      = 1'b1;
                            o_has_result  = 1'b1;
                            o_result.kind = ccgc_pkg::KIND_TOO_LONG;
                        end
                    end else begin
                        n_len = r_len + ccgc_pkg::LEN_W'(1);
                        if (r_len < ccgc_pkg::LEN_W'(3)) begin
                            unique case (r_len[1:0])
                                2'd0:    n_prefix[23:16] = r_prefix[23:16] | w_c;
                                2'd1:    n_prefix[15:8]  = r_prefix[15:8]  | w_c;
                                default: n_prefix[7:0]   = r_prefix[7:0]   | w_c;
                            endcase
                        end else begin
                            unique case (r_phase)
                                PH_SKIP: begin
                                    if (!w_is_space) begin
                                        n_phase = PH_DIGITS;
                                        if (w_c == ccgc_pkg::CH_MINUS) begin
                                            n_neg = 1'b1;
                                        end else if (w_c != ccgc_pkg::CH_PLUS) begin
                                            w_take_digit = 1'b1;
                                        end
                                    end
                                end
                                PH_DIGITS: w_take_digit = 1'b1;
                                default:   ;
                            endcase
                            if (w_take_digit) begin
                                if (w_is_digit) begin
                                    n_val = (w_acc > {3'b000, ccgc_pkg::VAL_CLAMP}) ?
                                            ccgc_pkg::VAL_CLAMP : w_acc[31:0];
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix  <= '0;
            r_len     <= '0;
            r_phase   <= PH_SKIP;
            r_neg     <= 1'b0;
            r_val     <= '0;
            r_acq     <= 1'b0;
            r_elapsed <= '0;
            r_window  <= '0;
            r_pulse   <= '0;
            r_warned  <= 1'b0;
        end else if (i_advance) begin
            r_prefix  <= n_prefix;
            r_len     <= n_len;
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_val     <= n_val;
            r_acq     <= n_acq;
            r_elapsed <= n_elapsed;
            r_window  <= n_window;
            r_pulse   <= n_pulse;
            r_warned  <= n_warned;
        end
    end

endmodule

FILE: hw/rtl/command_controlled_gated_counter.sv
// Items pass the input register; results enter the output queue.
// Throughput: one item per cycle when o_stall is low; the input register,
//   the single-pass engine and a two-entry output queue (result register
//   plus skid) set it.
// o_stall rises only while the output queue is full and an item is waiting.
// Reset (synchronous, active low) clears the line, window and counters.
// ---------------------------------------------------------------------------
// command_controlled_gated_counter
// Decodes serial command lines and counts pulse edges over a tick window.
// ---------------------------------------------------------------------------
module command_controlled_gated_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_pulse_total,
    output logic [3:0]  o_channel_select,
    output logic        o_enable_2r,
    output logic        o_low_rate
);

`include "command_controlled_gated_counter_assert.svh"

    logic               r_in_valid;
    ccgc_pkg::t_item    r_in;
    logic               r_out_valid;
    ccgc_pkg::t_result  r_out;
    logic               r_skid_valid;
    ccgc_pkg::t_result  r_skid;

    logic               w_advance;
    logic               w_pop;
    logic               w_has_result;
    logic               w_push;
    logic               w_load_out;
    logic               w_load_skid;
    ccgc_pkg::t_result  w_result;

    assign w_advance   = r_in_valid && !r_skid_valid;
    assign o_stall     = r_in_valid && r_skid_valid;
    assign w_pop       = r_out_valid && !i_stall;
    assign w_push      = w_advance && w_has_result;
    assign w_load_out  = w_pop || !r_out_valid;
    assign w_load_skid = r_out_valid && !w_pop && w_push;

    ccgc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_item       (r_in),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_load_out) begin
                r_out_valid <= r_skid_valid || w_push;
            end
            if (w_load_skid) begin
                r_skid_valid <= 1'b1;
            end else if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in.op      <= i_op;
            r_in.rx_byte <= i_rx_byte;
        end
        if (w_load_out) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (w_load_skid) begin
            r_skid <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_pulse_total    = r_out.pulse_total;
    assign o_channel_select = r_out.channel_select;
    assign o_enable_2r      = r_out.enable_2r;
    assign o_low_rate       = r_out.low_rate;

    // skid holds a result only behind a waiting result register
    `CCGC_ASSERT_IMPLIES(a_skid_behind_out, r_skid_valid, r_out_valid)
    // a transfer out of a full queue moves the skid entry forward
    `CCGC_ASSERT_NEXT(a_skid_drains, w_pop && r_skid_valid, r_out_valid && !r_skid_valid)
    // a new result behind a stalled result lands in the skid entry
    `CCGC_ASSERT_NEXT(a_push_to_skid, r_out_valid && i_stall && w_push, r_skid_valid)

endmodule
